// ----- rtl/hbr_pkg.sv -----
// ----------------------------------------------------------------------------
// hbr_pkg
// Shared types, constants and helpers for the hash bucket router.
// ----------------------------------------------------------------------------
package hbr_pkg;

	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned HASH_W       = 14;
	localparam int unsigned HASH_BASE    = 107;
	localparam int unsigned HASH_MOD     = 10000;
	// h*107 + byte stays below 2^21
	localparam int unsigned PROD_W       = 21;
	// floor(2^24 / 10000): quotient estimate is exact or one low
	localparam int unsigned RECIP        = 1677;
	localparam int unsigned RECIP_SHIFT  = 24;
	localparam int unsigned RECIP_PROD_W = 32;
	localparam int unsigned QUOT_W       = 7;

	localparam int unsigned BUCKET_W      = 11;
	localparam int unsigned CAP_W         = 24;
	localparam int unsigned MAX_BUCKETS   = 1024;
	localparam int unsigned RT_IDX_W      = 10;
	localparam int unsigned MAX_FILES_DEF = 1024;

	localparam int unsigned BUCKET_COUNT_RST    = 16;
	localparam int unsigned BUCKET_CAPACITY_RST = 3000000;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKET_COUNT    = 8'd0,
		REG_BUCKET_CAPACITY = 8'd1
	} hbr_reg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_byte;
		logic              last_char;
	} hbr_in_t;

	typedef struct packed {
		logic [HASH_W-1:0]   hash_value;
		logic [BUCKET_W-1:0] home_bucket;
		logic [BUCKET_W-1:0] target_file;
		logic [BUCKET_W-1:0] total_files;
		logic                table_full;
	} hbr_out_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic full;
	} hbr_tab_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_ROUTE,
		ST_EMIT
	} hbr_state_t;

	typedef enum logic [2:0] {
		TS_CLEAR,
		TS_IDLE,
		TS_RT,
		TS_CNT,
		TS_NEW,
		TS_FIN
	} hbr_tstate_t;

	// x mod 10000 for x up to 9999*107 + 255, by reciprocal multiply and one
	// correction; the quotient fits QUOT_W bits only in that range
	function automatic logic [HASH_W-1:0] hbr_mod10k(input logic [PROD_W-1:0] x);
		logic [RECIP_PROD_W-1:0] prod;
		logic [QUOT_W-1:0]       q;
		logic [PROD_W-1:0]       r;
		prod = RECIP_PROD_W'(x) * RECIP_PROD_W'(RECIP);
		q    = QUOT_W'(prod >> RECIP_SHIFT);
		r    = x - PROD_W'(q) * PROD_W'(HASH_MOD);
		if (r >= PROD_W'(HASH_MOD)) begin
			r = r - PROD_W'(HASH_MOD);
		end
		return HASH_W'(r);
	endfunction

endpackage

// ----- rtl/hbr_hash.sv -----
// ----------------------------------------------------------------------------
// hbr_hash
// Running polynomial hash: multiply-add on transfer, mod 10000 next cycle.
// ----------------------------------------------------------------------------
module hbr_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [hbr_pkg::CHAR_W-1:0] char_byte,
	input  logic                       last_char,
	input  logic                       step,
	output logic                       last_pending,
	output logic [hbr_pkg::HASH_W-1:0] hash_next,
	output logic [hbr_pkg::HASH_W-1:0] key_hash
);
	import hbr_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] key_hash_q;
	logic [PROD_W-1:0] prod_s1;
	logic              last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			last_s1 <= 1'b0;
		end else begin
			if (load) begin
				last_s1 <= last_char;
			end
			if (step) begin
				hash_q <= last_s1 ? '0 : hash_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(hash_q) * PROD_W'(HASH_BASE) + PROD_W'(char_byte);
		end
		if (step && last_s1) begin
			key_hash_q <= hash_next;
		end
	end

	assign hash_next    = hbr_mod10k(prod_s1);
	assign last_pending = last_s1;
	assign key_hash     = key_hash_q;

endmodule

// ----- rtl/hbr_modu.sv -----
// ----------------------------------------------------------------------------
// hbr_modu
// Restoring remainder unit: hash mod bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module hbr_modu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hbr_pkg::HASH_W-1:0]   dividend,
	input  logic [hbr_pkg::BUCKET_W-1:0] divisor,
	output logic                         done,
	output logic [hbr_pkg::BUCKET_W-1:0] remainder
);
	import hbr_pkg::*;

	localparam int unsigned CNT_W = $clog2(HASH_W);

	logic [HASH_W-1:0]   dvd_q;
	logic [BUCKET_W-1:0] dvs_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [BUCKET_W:0]   trial;
	logic                fits;

	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? BUCKET_W'(trial - {1'b0, dvs_q}) : BUCKET_W'(trial);
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/hbr_tables.sv -----
// ----------------------------------------------------------------------------
// hbr_tables
// Route table and per-file key counts in two synchronous RAMs, with the
// read-modify-write sequence for one key and the post-reset clearing sweep.
// ----------------------------------------------------------------------------
module hbr_tables #(
	parameter int unsigned MAX_FILES = hbr_pkg::MAX_FILES_DEF,
	parameter int unsigned FILE_W    = $clog2(MAX_FILES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [hbr_pkg::RT_IDX_W-1:0]   home_idx,
	input  logic [hbr_pkg::BUCKET_W-1:0]   buckets,
	input  logic [hbr_pkg::CAP_W-1:0]      capacity,
	output hbr_pkg::hbr_tab_stat_t         stat,
	output logic [FILE_W-1:0]              file,
	output logic [FILE_W-1:0]              total
);
	import hbr_pkg::*;

	localparam int unsigned IDX_W   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int unsigned SUM_W   = FILE_W + 1;
	localparam int unsigned CLR_LEN = (MAX_FILES > MAX_BUCKETS) ? MAX_FILES : MAX_BUCKETS;
	localparam int unsigned CLR_W   = $clog2(CLR_LEN);

	logic [FILE_W-1:0] route_mem [MAX_BUCKETS];
	logic [CAP_W-1:0]  cnt_mem   [MAX_FILES];

	hbr_tstate_t state_q, state_d;

	logic [CLR_W-1:0]    sweep_q;
	logic [CLR_W:0]      sweep_p1;
	logic [RT_IDX_W-1:0] home_q;
	logic [BUCKET_W-1:0] b_q;
	logic [CAP_W-1:0]    cap_q;
	logic [FILE_W-1:0]   file_q;
	logic [FILE_W-1:0]   extra_q;
	logic                full_q;
	logic [FILE_W-1:0]   rt_rd_q;
	logic [CAP_W-1:0]    cn_rd_q;

	logic                rt_we, rt_re;
	logic [RT_IDX_W-1:0] rt_wa, rt_ra;
	logic [FILE_W-1:0]   rt_wd;
	logic                cn_we, cn_re;
	logic [IDX_W-1:0]    cn_wa, cn_ra;
	logic [CAP_W-1:0]    cn_wd;

	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  new_file;
	logic              room;
	logic              spill;
	logic [CAP_W-1:0]  cnt_inc;

	assign sweep_p1 = {1'b0, sweep_q} + (CLR_W + 1)'(1);
	assign sum      = SUM_W'(b_q) + SUM_W'(extra_q);
	assign new_file = sum + SUM_W'(1);
	assign room     = sum < SUM_W'(MAX_FILES);
	assign spill    = cn_rd_q >= cap_q;
	// counts saturate at all ones
	assign cnt_inc  = (cn_rd_q == '1) ? cn_rd_q : cn_rd_q + CAP_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_CLEAR: if (sweep_q == CLR_W'(CLR_LEN - 1)) state_d = TS_IDLE;
			TS_IDLE:  if (start) state_d = TS_RT;
			TS_RT:    state_d = TS_CNT;
			TS_CNT:   state_d = (spill && room) ? TS_NEW : TS_FIN;
			TS_NEW:   state_d = TS_FIN;
			TS_FIN:   state_d = TS_IDLE;
			default:  state_d = TS_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rt_we = 1'b0;
		rt_wa = '0;
		rt_wd = '0;
		rt_re = 1'b0;
		rt_ra = '0;
		cn_we = 1'b0;
		cn_wa = '0;
		cn_wd = '0;
		cn_re = 1'b0;
		cn_ra = '0;
		unique case (state_q)
			TS_CLEAR: begin
				rt_we = {1'b0, sweep_q} < (CLR_W + 1)'(MAX_BUCKETS);
				rt_wa = sweep_q[RT_IDX_W-1:0];
				rt_wd = FILE_W'(sweep_p1);
				cn_we = {1'b0, sweep_q} < (CLR_W + 1)'(MAX_FILES);
				cn_wa = sweep_q[IDX_W-1:0];
				cn_wd = '0;
			end
			TS_IDLE: begin
				rt_re = start;
				rt_ra = home_idx;
			end
			TS_RT: begin
				cn_re = 1'b1;
				cn_ra = IDX_W'(rt_rd_q - FILE_W'(1));
			end
			TS_CNT: begin
				if (spill && room) begin
					rt_we = 1'b1;
					rt_wa = home_q;
					rt_wd = FILE_W'(new_file);
					cn_re = 1'b1;
					cn_ra = IDX_W'(sum);
				end else begin
					cn_we = 1'b1;
					cn_wa = IDX_W'(file_q - FILE_W'(1));
					cn_wd = cnt_inc;
				end
			end
			TS_NEW: begin
				cn_we = 1'b1;
				cn_wa = IDX_W'(file_q - FILE_W'(1));
				cn_wd = cnt_inc;
			end
			TS_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_CLEAR;
			sweep_q <= '0;
			extra_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == TS_CLEAR) begin
				sweep_q <= CLR_W'(sweep_p1);
			end
			if (state_q == TS_CNT && spill && room) begin
				extra_q <= extra_q + FILE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == TS_IDLE && start) begin
			home_q <= home_idx;
			b_q    <= buckets;
			cap_q  <= capacity;
		end
		if (state_q == TS_RT) begin
			file_q <= rt_rd_q;
			full_q <= 1'b0;
		end
		if (state_q == TS_CNT) begin
			if (spill && room) begin
				file_q <= FILE_W'(new_file);
			end else begin
				full_q <= spill;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rt_we) begin
			route_mem[rt_wa] <= rt_wd;
		end
		if (rt_re) begin
			rt_rd_q <= route_mem[rt_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cn_we) begin
			cnt_mem[cn_wa] <= cn_wd;
		end
		if (cn_re) begin
			cn_rd_q <= cnt_mem[cn_ra];
		end
	end

	assign stat.ready = state_q != TS_CLEAR;
	assign stat.done  = state_q == TS_FIN;
	assign stat.full  = full_q;
	assign file       = file_q;
	assign total      = room ? FILE_W'(sum) : FILE_W'(MAX_FILES);

endmodule

// ----- rtl/hash_bucket_router_with_spill.sv -----
// ----------------------------------------------------------------------------
// hash_bucket_router_with_spill
// Hashes keys one character per transfer and routes each finished key to an
// output file, spilling a full bucket to a new file while MAX_FILES allows.
// ----------------------------------------------------------------------------
//  channel | signals                        | transfer
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data    | one key character
//  out     | out_valid, out_ready, out_data | one result per finished key
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// A character that does not end a key passes the multiply-add, then the
// mod 10000 reduction. The final character then goes on to the bit-serial
// bucket remainder, the route/count RAM read-modify-write (through TS_NEW as
// well on a spill) and the load of the output register.
// After reset the RAMs are swept over max(1024, MAX_FILES) entries; in_ready
// stays low meanwhile. A result waiting at out stalls only the next key end.
// ----------------------------------------------------------------------------
module hash_bucket_router_with_spill #(
	parameter int unsigned MAX_FILES = hbr_pkg::MAX_FILES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  hbr_pkg::hbr_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output hbr_pkg::hbr_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hbr_pkg::*;

	localparam int unsigned FILE_W = $clog2(MAX_FILES + 1);
	localparam int unsigned B_MAX  = (MAX_FILES < MAX_BUCKETS) ? MAX_FILES : MAX_BUCKETS;

	hbr_state_t state_q, state_d;

	logic [BUCKET_W-1:0] bucket_count_q;
	logic [CAP_W-1:0]    bucket_capacity_q;
	logic [BUCKET_W-1:0] b_eff;

	logic                in_fire;
	logic                hash_step;
	logic                mod_start;
	logic                tab_start;
	logic                out_free;
	logic                out_load;
	logic                out_valid_q;
	hbr_out_t            out_q;

	logic                last_pending;
	logic [HASH_W-1:0]   hash_next;
	logic [HASH_W-1:0]   key_hash;
	logic                mod_done;
	logic [BUCKET_W-1:0] rem;
	hbr_tab_stat_t       tab_stat;
	logic [FILE_W-1:0]   tab_file;
	logic [FILE_W-1:0]   tab_total;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q    <= BUCKET_W'(BUCKET_COUNT_RST);
			bucket_capacity_q <= CAP_W'(BUCKET_CAPACITY_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BUCKET_COUNT:    bucket_count_q    <= cfg_data[BUCKET_W-1:0];
				REG_BUCKET_CAPACITY: bucket_capacity_q <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (bucket_count_q == '0) begin
			b_eff = BUCKET_W'(1);
		end else if (bucket_count_q > BUCKET_W'(B_MAX)) begin
			b_eff = BUCKET_W'(B_MAX);
		end else begin
			b_eff = bucket_count_q;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_HASH;
			ST_HASH:  state_d = last_pending ? ST_MOD : ST_IDLE;
			ST_MOD:   if (mod_done) state_d = ST_ROUTE;
			ST_ROUTE: if (tab_stat.done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		hash_step = 1'b0;
		mod_start = 1'b0;
		tab_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = tab_stat.ready;
			ST_HASH: begin
				hash_step = 1'b1;
				mod_start = last_pending;
			end
			ST_MOD:   tab_start = mod_done;
			ST_ROUTE: begin
			end
			ST_EMIT:  out_load = out_free;
			default: begin
			end
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.hash_value  <= key_hash;
			out_q.home_bucket <= rem + BUCKET_W'(1);
			out_q.target_file <= BUCKET_W'(tab_file);
			out_q.total_files <= BUCKET_W'(tab_total);
			out_q.table_full  <= tab_stat.full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	hbr_hash u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_fire),
		.char_byte    (in_data.char_byte),
		.last_char    (in_data.last_char),
		.step         (hash_step),
		.last_pending (last_pending),
		.hash_next    (hash_next),
		.key_hash     (key_hash)
	);

	hbr_modu u_modu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_next),
		.divisor   (b_eff),
		.done      (mod_done),
		.remainder (rem)
	);

	hbr_tables #(
		.MAX_FILES (MAX_FILES),
		.FILE_W    (FILE_W)
	) u_tables (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tab_start),
		.home_idx (rem[RT_IDX_W-1:0]),
		.buckets  (b_eff),
		.capacity (bucket_capacity_q),
		.stat     (tab_stat),
		.file     (tab_file),
		.total    (tab_total)
	);

endmodule
